FILE: design/apr_pkg.sv
package apr_pkg;

   // default message length in characters, at least one full position report
   localparam int PAYLOAD_CHARS_DEF = 28;

   localparam int SIXBIT_W  = 6;
   localparam int CHAR_W    = 8;
   localparam int MSG_CHARS = 28;
   localparam int MSG_BITS  = MSG_CHARS * SIXBIT_W;

   localparam int NUM_FIELDS    = 15;
   localparam int FIELD_ID_W    = 4;
   localparam int FIELD_VALUE_W = 30;
   localparam int RSP_TDATA_W   = 40;

   localparam int QUEUE_DEPTH = 2;

   // armoring table ranges
   localparam logic [CHAR_W-1:0]   CHAR_LO_BASE = 8'h30;
   localparam logic [CHAR_W-1:0]   CHAR_LO_LAST = 8'h57;
   localparam logic [CHAR_W-1:0]   CHAR_HI_BASE = 8'h60;
   localparam logic [CHAR_W-1:0]   CHAR_HI_LAST = 8'h77;
   localparam logic [SIXBIT_W-1:0] HI_OFFSET    = 6'd40;

   localparam logic [FIELD_ID_W-1:0] LAST_FIELD_ID = FIELD_ID_W'(NUM_FIELDS - 1);

   typedef logic [FIELD_ID_W-1:0] field_id_type;

   // one complete message handed from front to back
   typedef struct packed {
      logic                short_payload;
      logic [MSG_BITS-1:0] bits;
   } msg_type;

   // position report layout, bit 0 is the msb of the first character
   function automatic int fld_start(input int k);
      case (k)
         0:       return 0;
         1:       return 6;
         2:       return 8;
         3:       return 38;
         4:       return 42;
         5:       return 50;
         6:       return 60;
         7:       return 61;
         8:       return 89;
         9:       return 116;
         10:      return 128;
         11:      return 137;
         12:      return 143;
         13:      return 148;
         default: return 149;
      endcase
   endfunction

   function automatic int fld_len(input int k);
      case (k)
         0:       return 6;
         1:       return 2;
         2:       return 30;
         3:       return 4;
         4:       return 8;
         5:       return 10;
         6:       return 1;
         7:       return 28;
         8:       return 27;
         9:       return 12;
         10:      return 9;
         11:      return 6;
         12:      return 2;
         13:      return 1;
         default: return 19;
      endcase
   endfunction

   function automatic logic [SIXBIT_W-1:0] dearmor(input logic [CHAR_W-1:0] c);
      logic [SIXBIT_W-1:0] v;
      v = '0;
      if (c inside {[CHAR_LO_BASE:CHAR_LO_LAST]}) begin
         v = SIXBIT_W'(c - CHAR_LO_BASE);
      end else if (c inside {[CHAR_HI_BASE:CHAR_HI_LAST]}) begin
         v = SIXBIT_W'(c - CHAR_HI_BASE) + HI_OFFSET;
      end
      return v;
   endfunction

   // bits are kept msb first: position p sits at vector bit MSG_BITS-1-p
   function automatic logic [FIELD_VALUE_W-1:0] field_extract(
      input logic [MSG_BITS-1:0] bits,
      input int                  start,
      input int                  len
   );
      logic [MSG_BITS-1:0]      shifted;
      logic [FIELD_VALUE_W:0]   mask;
      shifted = bits >> (MSG_BITS - start - len);
      mask    = ((FIELD_VALUE_W + 1)'(1) << len) - (FIELD_VALUE_W + 1)'(1);
      return shifted[FIELD_VALUE_W-1:0] & mask[FIELD_VALUE_W-1:0];
   endfunction

endpackage

FILE: design/ais_position_report_decoder.sv
// a message is registered into the message queue when its tlast beat is accepted;
//   its first field beat is then registered into the back end's output register
// throughput: one payload character per cycle while req_tready is high; the back
//   end's counter sends each message as 15 field beats, one per cycle of rsp_tready
// the two-entry message queue stalls req_tready only when two messages wait
// reset: synchronous, active high; clears the character store, count, queue and back end
module ais_position_report_decoder #(
   parameter int PAYLOAD_CHARS = apr_pkg::PAYLOAD_CHARS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [7:0] payload_char
   input  logic [apr_pkg::CHAR_W-1:0]         req_tdata,
   input  logic                               req_tlast,   // end_of_payload
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: [3:0] field_id, [33:4] field_value, [39:34] zero
   output logic [apr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: [0] short_payload
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,   // last_field
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);
   import apr_pkg::*;

   // front to queue
   logic                     push;
   msg_type                  push_msg;
   logic                     queue_full;

   // queue to back
   logic                     head_valid;
   msg_type                  head_msg;
   logic                     pop;

   // back end result beat
   field_id_type             field_id;
   logic [FIELD_VALUE_W-1:0] field_value;

   // front: de-armor each character into the six-bit store, snapshot on tlast
   apr_front #(
      .PAYLOAD_CHARS (PAYLOAD_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_char   (req_tdata),
      .req_last   (req_tlast),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .queue_full (queue_full),
      .push       (push),
      .push_msg   (push_msg)
   );

   // short queue of complete messages decouples front and back
   apr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_msg   (push_msg),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_msg   (head_msg)
   );

   // back: walk the fifteen report fields into a registered output beat
   apr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_msg        (head_msg),
      .pop             (pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_field_id    (field_id),
      .rsp_field_value (field_value),
      .rsp_short       (rsp_tuser),
      .rsp_last        (rsp_tlast)
   );

   // pack result fields, low field first, zero fill to whole bytes
   assign rsp_tdata = {
      (RSP_TDATA_W - FIELD_VALUE_W - FIELD_ID_W)'(0), field_value, field_id
   };

   // tlast marks exactly the radio status field
   a_last_on_final_field : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[FIELD_ID_W-1:0] == LAST_FIELD_ID)))
      else $error("tlast does not match the final field id");

   // field ids stay within the report layout
   a_field_id_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[FIELD_ID_W-1:0] <= LAST_FIELD_ID))
      else $error("field id out of range");

   // a message enters the queue only when there is room for it
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("message pushed into a full queue");

   // no result beat directly after reset
   a_idle_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat valid right after reset");

endmodule

FILE: design/apr_front.sv
module apr_front #(
   parameter int PAYLOAD_CHARS = apr_pkg::PAYLOAD_CHARS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [apr_pkg::CHAR_W-1:0]   req_char,
   input  logic                         req_last,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         queue_full,
   output logic                         push,
   output apr_pkg::msg_type             push_msg
);
   import apr_pkg::*;

   localparam int COUNT_W = $clog2(PAYLOAD_CHARS + 1);

   // only the characters that carry report bits are kept
   logic [MSG_CHARS-1:0][SIXBIT_W-1:0]     store_ff, store_in;
   logic [MSG_CHARS-1:0][SIXBIT_W-1:0]     merged;
   logic [COUNT_W-1:0]                     count_ff, count_in;
   logic [SIXBIT_W-1:0]                    sixbit;
   logic                                   accept;
   logic                                   room;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign sixbit    = dearmor(req_char);
   assign room      = count_ff < COUNT_W'(PAYLOAD_CHARS);

   // store with the current character dropped into its slot
   always_comb begin
      for (int i = 0; i < MSG_CHARS; i++) begin
         merged[i] = (count_ff == COUNT_W'(i)) ? sixbit : store_ff[i];
      end
   end

   always_comb begin
      push_msg.short_payload = count_ff < COUNT_W'(PAYLOAD_CHARS - 1);
      for (int i = 0; i < MSG_CHARS; i++) begin
         push_msg.bits[MSG_BITS-1-SIXBIT_W*i -: SIXBIT_W] = merged[i];
      end
   end

   assign push = accept && req_last;

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_last) begin
            store_in = '0;
            count_in = '0;
         end else begin
            store_in = merged;
            if (room) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         count_ff <= '0;
      end else begin
         store_ff <= store_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/apr_queue.sv
module apr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  apr_pkg::msg_type push_msg,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output apr_pkg::msg_type head_msg
);
   import apr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   msg_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   level_ff, level_in;
   logic               do_push, do_pop;

   assign full       = level_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = level_ff != '0;
   assign head_msg   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_msg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

FILE: design/apr_back.sv
module apr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  apr_pkg::msg_type                   head_msg,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output apr_pkg::field_id_type              rsp_field_id,
   output logic [apr_pkg::FIELD_VALUE_W-1:0]  rsp_field_value,
   output logic                               rsp_short,
   output logic                               rsp_last
);
   import apr_pkg::*;

   logic [FIELD_VALUE_W-1:0] field_val [NUM_FIELDS];
   field_id_type             cnt_ff, cnt_in;
   logic                     valid_ff, valid_in;
   field_id_type             id_ff, id_in;
   logic [FIELD_VALUE_W-1:0] value_ff, value_in;
   logic                     short_ff, short_in;
   logic                     last_ff, last_in;
   logic                     load;
   logic                     at_last;

   always_comb begin
      for (int k = 0; k < NUM_FIELDS; k++) begin
         field_val[k] = field_extract(head_msg.bits, fld_start(k), fld_len(k));
      end
   end

   assign at_last = cnt_ff == LAST_FIELD_ID;
   assign load    = head_valid && (!valid_ff || rsp_ready);
   assign pop     = load && at_last;

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      id_in    = id_ff;
      value_in = value_ff;
      short_in = short_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         id_in    = cnt_ff;
         value_in = field_val[cnt_ff];
         short_in = head_msg.short_payload;
         last_in  = at_last;
         cnt_in   = at_last ? '0 : cnt_ff + FIELD_ID_W'(1);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      value_ff <= value_in;
      short_ff <= short_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_field_id    = id_ff;
   assign rsp_field_value = value_ff;
   assign rsp_short       = short_ff;
   assign rsp_last        = last_ff;

endmodule

FILE: tb/ais_position_report_decoder_tb.sv
module ais_position_report_decoder_tb;

   // message geometry of a type 1-3 position report
   localparam int REPORT_CHARS = 28;
   localparam int REPORT_BITS  = REPORT_CHARS * 6;
   localparam int REPORT_FIELDS = 15;

   // cycles without any accepted beat before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // length of the long receiver hold-off used to back the block up
   localparam int HOLD_CYCLES = 200;
   // random stimulus budget in payload characters
   localparam int RANDOM_CHARS = 130;

   // one expected field beat on the result side
   typedef struct {
      logic [3:0]  id;
      logic [29:0] value;
      logic        short_flag;
      logic        last_flag;
   } field_beat_type;

   // predicts the field beats of each message and checks them in order
   class report_scoreboard;
      logic [REPORT_BITS-1:0] msg_bits;   // position p sits at bit REPORT_BITS-1-p
      int unsigned            chars_held;
      field_beat_type         expected_fields[$];
      int unsigned            mismatches;
      int unsigned            fields_checked;
      int unsigned            messages_seen;

      function new();
         msg_bits       = '0;
         chars_held     = 0;
         mismatches     = 0;
         fields_checked = 0;
         messages_seen  = 0;
      endfunction

      // standard six-bit armoring, anything off the table reads as zero
      function logic [5:0] sixbit_of(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h57) begin
            return 6'(c - 8'h30);
         end else if (c >= 8'h60 && c <= 8'h77) begin
            return 6'(c - 8'h60 + 8'd40);
         end
         return 6'd0;
      endfunction

      // bit offset and width of each report field, spare bits 145..147 skipped
      function void field_span(int k, output int first_bit, output int width);
         case (k)
            0: begin first_bit = 0;   width = 6;  end
            1: begin first_bit = 6;   width = 2;  end
            2: begin first_bit = 8;   width = 30; end
            3: begin first_bit = 38;  width = 4;  end
            4: begin first_bit = 42;  width = 8;  end
            5: begin first_bit = 50;  width = 10; end
            6: begin first_bit = 60;  width = 1;  end
            7: begin first_bit = 61;  width = 28; end
            8: begin first_bit = 89;  width = 27; end
            9: begin first_bit = 116; width = 12; end
            10: begin first_bit = 128; width = 9; end
            11: begin first_bit = 137; width = 6; end
            12: begin first_bit = 143; width = 2; end
            13: begin first_bit = 148; width = 1; end
            default: begin first_bit = 149; width = 19; end
         endcase
      endfunction

      function logic [29:0] field_bits(int first_bit, int width);
         logic [29:0] v;
         v = '0;
         for (int i = 0; i < width; i++) begin
            v = {v[28:0], msg_bits[REPORT_BITS-1-(first_bit+i)]};
         end
         return v;
      endfunction

      // one accepted payload character
      function void note_char(logic [7:0] c, logic last);
         int             first_bit;
         int             width;
         field_beat_type beat;
         if (chars_held < REPORT_CHARS) begin
            msg_bits[REPORT_BITS-1-6*chars_held -: 6] = sixbit_of(c);
            chars_held++;
         end
         if (last) begin
            for (int k = 0; k < REPORT_FIELDS; k++) begin
               field_span(k, first_bit, width);
               beat.id         = 4'(k);
               beat.value      = field_bits(first_bit, width);
               beat.short_flag = (chars_held < REPORT_CHARS);
               beat.last_flag  = (k == REPORT_FIELDS - 1);
               expected_fields.push_back(beat);
            end
            msg_bits   = '0;
            chars_held = 0;
            messages_seen++;
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      // one accepted field beat
      task check_field(logic [apr_pkg::RSP_TDATA_W-1:0] tdata, logic tuser, logic tlast);
         field_beat_type want;
         if (expected_fields.size() == 0) begin
            report_mismatch($sformatf("field beat %h with nothing outstanding", tdata));
            return;
         end
         want = expected_fields.pop_front();
         fields_checked++;
         if (tdata[3:0] !== want.id)
            report_mismatch($sformatf("field_id got %0d want %0d", tdata[3:0], want.id));
         if (tdata[33:4] !== want.value)
            report_mismatch($sformatf("field %0d value got %h want %h",
                                      want.id, tdata[33:4], want.value));
         if (tdata[39:34] !== 6'd0)
            report_mismatch($sformatf("field %0d pad bits got %h", want.id, tdata[39:34]));
         if (tuser !== want.short_flag)
            report_mismatch($sformatf("field %0d short_payload got %b want %b",
                                      want.id, tuser, want.short_flag));
         if (tlast !== want.last_flag)
            report_mismatch($sformatf("field %0d last_field got %b want %b",
                                      want.id, tlast, want.last_flag));
      endtask

      function int pending();
         return expected_fields.size();
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   // req_tdata: [7:0] payload_char
   logic [apr_pkg::CHAR_W-1:0]         req_tdata = '0;
   logic                               req_tlast = 1'b0;   // end_of_payload
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   // rsp_tdata: [3:0] field_id, [33:4] field_value, [39:34] zero
   logic [apr_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   // rsp_tuser: [0] short_payload
   logic                               rsp_tuser;
   logic                               rsp_tlast;          // last_field
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;

   report_scoreboard sb = new();

   // idle percentages of the two sides, changed per phase by the stimulus
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   // hold-off requests from the stimulus, served by the receiver process
   int unsigned hold_req = 0;
   int unsigned hold_ack = 0;
   int unsigned hold_left = 0;
   int unsigned chars_sent = 0;
   int unsigned quiet_cycles = 0;

   ais_position_report_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #5 clock = ~clock;

   // receiver: random back-pressure, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack  = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result monitor and hang watchdog, both on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         sb.check_field(rsp_tdata, rsp_tuser, rsp_tlast);
      end
      if (!reset && ((rsp_tvalid === 1'b1 && rsp_tready) ||
                     (req_tvalid && req_tready === 1'b1))) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
         $display("ais_position_report_decoder regression: fail");
         $finish;
      end
   end

   // one payload character; entered and left at a falling edge
   task send_char(logic [7:0] c, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = c;
      req_tlast  = last;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_char(c, last);
      chars_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // mostly characters from the armoring table, sometimes any byte
   function logic [7:0] random_char();
      int unsigned v;
      if ($urandom_range(99) < 80) begin
         v = $urandom_range(63);
         return (v < 40) ? 8'(8'h30 + v) : 8'(8'h60 + v - 40);
      end
      return 8'($urandom_range(255));
   endfunction

   // a message of len characters, random content or one repeated character
   task send_message(int len, int fill);
      for (int i = 0; i < len; i++) begin
         send_char((fill < 0) ? random_char() : 8'(fill), i == len - 1);
      end
   endtask

   // sender pause: wait until every predicted field beat has arrived
   task wait_drained();
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // full length most of the time, short and overlong runs mixed in
   function int random_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return REPORT_CHARS;
      if (r < 85) return $urandom_range(REPORT_CHARS - 1, 1);
      return $urandom_range(REPORT_CHARS + 12, REPORT_CHARS + 1);
   endfunction

   initial begin
      int unsigned base;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: one-character message of a zero byte, all fields read zero
      send_char(8'h00, 1'b1);
      // table edges, characters just outside both ranges, and the all-ones byte
      send_char(8'h2f, 1'b0);
      send_char(8'h30, 1'b0);
      send_char(8'h57, 1'b0);
      send_char(8'h58, 1'b0);
      send_char(8'h5f, 1'b0);
      send_char(8'h60, 1'b0);
      send_char(8'h77, 1'b0);
      send_char(8'h78, 1'b0);
      send_char(8'hff, 1'b0);
      send_char(8'h77, 1'b1);
      wait_drained();

      // back the block up: receiver holds off while short messages keep coming
      hold_req++;
      repeat (4) send_message(3, -1);
      wait_drained();

      // full all-ones report, then one that runs past the store
      send_message(REPORT_CHARS, 8'h77);
      send_message(REPORT_CHARS + 6, -1);
      wait_drained();

      // random messages over three idling phases
      base = chars_sent;
      while (chars_sent - base < RANDOM_CHARS) begin
         if (chars_sent - base < RANDOM_CHARS / 3) begin
            send_idle_pct = 15;
            recv_idle_pct = 57;
         end else if (chars_sent - base < 2 * RANDOM_CHARS / 3) begin
            send_idle_pct = 57;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_message(random_length(), -1);
      end

      // drain and let any stray beats show up
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("covered %0d messages, %0d characters, %0d field beats checked",
               sb.messages_seen, chars_sent, sb.fields_checked);
      $display("short, full and overlong payloads, off-table characters, input stall");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ais_position_report_decoder regression: pass");
      end else begin
         $display("ais_position_report_decoder regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/apr_pkg.sv
design/apr_front.sv
design/apr_queue.sv
design/apr_back.sv
design/ais_position_report_decoder.sv
tb/ais_position_report_decoder_tb.sv
